// ----- sv/jsu_pkg.sv -----
// Shared types and codes for the JSON string unescape and UTF-8 encode block.
package jsu_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE      = 4'd1;
    localparam logic [3:0] ERR_UNTERMINATED  = 4'd2;
    localparam logic [3:0] ERR_CONTROL_CHAR  = 4'd3;
    localparam logic [3:0] ERR_TRUNC_ESCAPE  = 4'd4;
    localparam logic [3:0] ERR_UNKNOWN_ESC   = 4'd5;
    localparam logic [3:0] ERR_TRUNC_HEX     = 4'd6;
    localparam logic [3:0] ERR_BAD_HEX       = 4'd7;
    localparam logic [3:0] ERR_BAD_LOW       = 4'd8;
    localparam logic [3:0] ERR_UNPAIRED_HIGH = 4'd9;
    localparam logic [3:0] ERR_UNPAIRED_LOW  = 4'd10;

    // Most results one input byte can cause (a four-byte UTF-8 sequence).
    localparam int RES_DEPTH = 4;
    localparam int REM_W     = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [3:0] code;
    } res_t;

endpackage

// ----- sv/json_string_unescape_utf8.sv -----
// Top level of the JSON string unescape and UTF-8 encode block.
//
// Bytes of a JSON text enter one per transfer; the block finds the opening quote, decodes
// escapes and \u sequences (including surrogate pairs) into UTF-8 bytes, and reports the
// closing quote or the first error, after which it waits for the next quote. An input
// transfer goes into an input register, is decoded there and its results are loaded into a
// four-entry result buffer that drains one result per cycle while dst_ready is high. An item
// that causes at most one result lets a byte be taken every cycle while the output is not
// stalled; an item that expands into two to four UTF-8 bytes keeps the result buffer busy
// until they drain, while the input register holds the next item and the input side stalls.
module json_string_unescape_utf8
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       src_valid,
    output logic       src_ready,
    input  logic [7:0] byte_value,
    input  logic       text_ended,

    output logic       dst_valid,
    input  logic       dst_ready,
    output logic [7:0] out_byte,
    output logic [1:0] result_kind,
    output logic [3:0] error_code,
    output logic       last_of_run
);

    typedef enum logic [2:0] {
        MODE_WAIT,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX_FIRST,
        MODE_PAIR_BS,
        MODE_PAIR_U,
        MODE_HEX_LOW
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Input register.
    logic       src_full_reg;
    logic [7:0] byte_reg;
    logic       ended_reg;

    // Decoder state.
    mode_t       mode_reg, mode_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic        bad_hex_reg, bad_hex_next;
    logic [9:0]  high_half_reg, high_half_next;

    // Result buffer; entry 0 is presented on the output.
    jsu_pkg::res_t                 res_reg [jsu_pkg::RES_DEPTH];
    jsu_pkg::res_t                 res_next [jsu_pkg::RES_DEPTH];
    jsu_pkg::res_t                 new_res [jsu_pkg::RES_DEPTH];
    logic [jsu_pkg::REM_W-1:0]     rem_reg, rem_next, new_cnt;

    logic dst_fire;
    logic buf_free;
    logic dec_fire;

    // Decode helpers.
    logic        is_hex;
    logic [3:0]  digit;
    logic [15:0] acc_shift;
    logic        bad_shift;
    logic        put_err, put_close, put_byte, put_cp;
    logic [3:0]  err_c;
    logic [7:0]  byte_c;
    logic [20:0] cp_c;

    assign dst_fire = dst_valid && dst_ready;
    // The buffer can take a new run when it is empty or its last result leaves now.
    assign buf_free = (rem_reg == '0) || ((rem_reg == jsu_pkg::REM_W'(1)) && dst_ready);
    assign dec_fire = src_full_reg && buf_free;
    assign src_ready = !src_full_reg || dec_fire;

    assign dst_valid   = (rem_reg != '0);
    assign last_of_run = (rem_reg == jsu_pkg::REM_W'(1));
    assign out_byte    = res_reg[0].data;
    assign result_kind = res_reg[0].kind;
    assign error_code  = res_reg[0].code;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (byte_reg >= 8'h30 && byte_reg <= 8'h39)
        begin
            digit = byte_reg[3:0];
        end
        else if ((byte_reg >= 8'h61 && byte_reg <= 8'h66) ||
                 (byte_reg >= 8'h41 && byte_reg <= 8'h46))
        begin
            digit = byte_reg[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
        acc_shift = {hex_accum_reg[11:0], digit};
        bad_shift = bad_hex_reg || !is_hex;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        hex_accum_next = hex_accum_reg;
        hex_count_next = hex_count_reg;
        bad_hex_next   = bad_hex_reg;
        high_half_next = high_half_reg;
        put_err   = 1'b0;
        put_close = 1'b0;
        put_byte  = 1'b0;
        put_cp    = 1'b0;
        err_c     = jsu_pkg::ERR_NONE;
        byte_c    = byte_reg;
        cp_c      = {5'd0, acc_shift};

        if (ended_reg)
        begin
            case (mode_reg)
                MODE_BODY:
                begin
                    put_err = 1'b1;
                    err_c   = jsu_pkg::ERR_UNTERMINATED;
                end
                MODE_ESC:
                begin
                    put_err = 1'b1;
                    err_c   = jsu_pkg::ERR_TRUNC_ESCAPE;
                end
                MODE_HEX_FIRST, MODE_HEX_LOW:
                begin
                    put_err = 1'b1;
                    err_c   = jsu_pkg::ERR_TRUNC_HEX;
                end
                MODE_PAIR_BS, MODE_PAIR_U:
                begin
                    put_err = 1'b1;
                    err_c   = jsu_pkg::ERR_UNPAIRED_HIGH;
                end
                default:
                begin
                    mode_next = MODE_WAIT;
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_BODY:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        put_close = 1'b1;
                        mode_next = MODE_WAIT;
                    end
                    else if (byte_reg < 8'h20)
                    begin
                        put_err = 1'b1;
                        err_c   = jsu_pkg::ERR_CONTROL_CHAR;
                    end
                    else if (byte_reg == CH_BSL)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        put_byte = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_BODY;
                    put_byte  = 1'b1;
                    case (byte_reg)
                        CH_QUOTE, CH_BSL, CH_SLASH: byte_c = byte_reg;
                        CH_B: byte_c = 8'h08;
                        CH_F: byte_c = 8'h0C;
                        CH_N: byte_c = 8'h0A;
                        CH_R: byte_c = 8'h0D;
                        CH_T: byte_c = 8'h09;
                        CH_U:
                        begin
                            put_byte       = 1'b0;
                            mode_next      = MODE_HEX_FIRST;
                            hex_accum_next = 16'd0;
                            hex_count_next = 2'd0;
                            bad_hex_next   = 1'b0;
                        end
                        default:
                        begin
                            put_byte = 1'b0;
                            put_err  = 1'b1;
                            err_c    = jsu_pkg::ERR_UNKNOWN_ESC;
                        end
                    endcase
                end
                MODE_HEX_FIRST, MODE_HEX_LOW:
                begin
                    hex_accum_next = acc_shift;
                    bad_hex_next   = bad_shift;
                    if (hex_count_reg != 2'd3)
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else
                    begin
                        hex_count_next = 2'd0;
                        if (bad_shift)
                        begin
                            put_err = 1'b1;
                            err_c   = jsu_pkg::ERR_BAD_HEX;
                        end
                        else if (mode_reg == MODE_HEX_FIRST)
                        begin
                            if (acc_shift[15:10] == 6'b110110)
                            begin
                                high_half_next = acc_shift[9:0];
                                mode_next      = MODE_PAIR_BS;
                            end
                            else if (acc_shift[15:10] == 6'b110111)
                            begin
                                put_err = 1'b1;
                                err_c   = jsu_pkg::ERR_UNPAIRED_LOW;
                            end
                            else
                            begin
                                put_cp    = 1'b1;
                                mode_next = MODE_BODY;
                            end
                        end
                        else if (acc_shift[15:10] != 6'b110111)
                        begin
                            put_err = 1'b1;
                            err_c   = jsu_pkg::ERR_BAD_LOW;
                        end
                        else
                        begin
                            put_cp    = 1'b1;
                            cp_c      = 21'h010000 + {1'b0, high_half_reg, acc_shift[9:0]};
                            mode_next = MODE_BODY;
                        end
                    end
                end
                MODE_PAIR_BS:
                begin
                    if (byte_reg == CH_BSL)
                    begin
                        mode_next = MODE_PAIR_U;
                    end
                    else
                    begin
                        put_err = 1'b1;
                        err_c   = jsu_pkg::ERR_UNPAIRED_HIGH;
                    end
                end
                MODE_PAIR_U:
                begin
                    if (byte_reg == CH_U)
                    begin
                        mode_next      = MODE_HEX_LOW;
                        hex_accum_next = 16'd0;
                        hex_count_next = 2'd0;
                        bad_hex_next   = 1'b0;
                    end
                    else
                    begin
                        put_err = 1'b1;
                        err_c   = jsu_pkg::ERR_UNPAIRED_HIGH;
                    end
                end
                default:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        mode_next = MODE_BODY;
                    end
                    else
                    begin
                        put_err = 1'b1;
                        err_c   = jsu_pkg::ERR_NO_QUOTE;
                    end
                end
            endcase
        end

        if (put_err)
        begin
            mode_next = MODE_WAIT;
        end
    end

    // Builds the run of results for the item in the input register.
    always_comb
    begin
        for (int i = 0; i < jsu_pkg::RES_DEPTH; i++)
        begin
            new_res[i] = '{data: 8'd0, kind: jsu_pkg::KIND_BYTE, code: jsu_pkg::ERR_NONE};
        end
        new_cnt = '0;
        if (put_err)
        begin
            new_res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_ERROR, code: err_c};
            new_cnt    = jsu_pkg::REM_W'(1);
        end
        else if (put_close)
        begin
            new_res[0].kind = jsu_pkg::KIND_CLOSED;
            new_cnt         = jsu_pkg::REM_W'(1);
        end
        else if (put_byte)
        begin
            new_res[0].data = byte_c;
            new_cnt         = jsu_pkg::REM_W'(1);
        end
        else if (put_cp)
        begin
            if (cp_c[20:7] == '0)
            begin
                new_res[0].data = cp_c[7:0];
                new_cnt         = jsu_pkg::REM_W'(1);
            end
            else if (cp_c[20:11] == '0)
            begin
                new_res[0].data = {3'b110, cp_c[10:6]};
                new_res[1].data = {2'b10, cp_c[5:0]};
                new_cnt         = jsu_pkg::REM_W'(2);
            end
            else if (cp_c[20:16] == '0)
            begin
                new_res[0].data = {4'b1110, cp_c[15:12]};
                new_res[1].data = {2'b10, cp_c[11:6]};
                new_res[2].data = {2'b10, cp_c[5:0]};
                new_cnt         = jsu_pkg::REM_W'(3);
            end
            else
            begin
                new_res[0].data = {5'b11110, cp_c[20:18]};
                new_res[1].data = {2'b10, cp_c[17:12]};
                new_res[2].data = {2'b10, cp_c[11:6]};
                new_res[3].data = {2'b10, cp_c[5:0]};
                new_cnt         = jsu_pkg::REM_W'(4);
            end
        end
    end

    always_comb
    begin
        res_next = res_reg;
        rem_next = rem_reg;
        if (dst_fire)
        begin
            for (int i = 0; i < jsu_pkg::RES_DEPTH - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            rem_next = rem_reg - jsu_pkg::REM_W'(1);
        end
        if (dec_fire)
        begin
            res_next = new_res;
            rem_next = new_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_full_reg  <= 1'b0;
            byte_reg      <= 8'd0;
            ended_reg     <= 1'b0;
            mode_reg      <= MODE_WAIT;
            hex_accum_reg <= 16'd0;
            hex_count_reg <= 2'd0;
            bad_hex_reg   <= 1'b0;
            high_half_reg <= 10'd0;
            rem_reg       <= '0;
            for (int i = 0; i < jsu_pkg::RES_DEPTH; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        else
        begin
            if (src_valid && src_ready)
            begin
                src_full_reg <= 1'b1;
                byte_reg     <= byte_value;
                ended_reg    <= text_ended;
            end
            else if (dec_fire)
            begin
                src_full_reg <= 1'b0;
            end
            if (dec_fire)
            begin
                mode_reg      <= mode_next;
                hex_accum_reg <= hex_accum_next;
                hex_count_reg <= hex_count_next;
                bad_hex_reg   <= bad_hex_next;
                high_half_reg <= high_half_next;
            end
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

endmodule

// ----- sv/jsu_checker.sv -----
// Port-level assertions for the JSON string unescape block, with their bind.
module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       dst_valid,
    input logic       dst_ready,
    input logic [7:0] out_byte,
    input logic [1:0] result_kind,
    input logic [3:0] error_code,
    input logic       last_of_run
);

    logic dst_fire;
    assign dst_fire = dst_valid && dst_ready;

    // An error ends its run and carries a real code and no byte.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        dst_fire && result_kind == jsu_pkg::KIND_ERROR |->
            last_of_run && out_byte == 8'd0 && error_code != jsu_pkg::ERR_NONE &&
            error_code <= jsu_pkg::ERR_UNPAIRED_LOW)
        else $error("malformed error result");

    // A close ends its run and carries neither byte nor code.
    a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
        dst_fire && result_kind == jsu_pkg::KIND_CLOSED |->
            last_of_run && out_byte == 8'd0 && error_code == jsu_pkg::ERR_NONE)
        else $error("malformed close result");

    // Only UTF-8 sequences span several results, and the rest of the run follows at once.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        dst_fire && !last_of_run |->
            result_kind == jsu_pkg::KIND_BYTE ##1
            dst_valid && result_kind == jsu_pkg::KIND_BYTE)
        else $error("multi-result run broken");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=>
            dst_valid && $stable(out_byte) && $stable(result_kind) &&
            $stable(error_code) && $stable(last_of_run))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .dst_valid   (dst_valid),
    .dst_ready   (dst_ready),
    .out_byte    (out_byte),
    .result_kind (result_kind),
    .error_code  (error_code),
    .last_of_run (last_of_run)
);
